/* rtl/round_robin_time_slice_scheduler_macros.svh */
// Assertion macros for the round-robin time-slice scheduler.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef ROUND_ROBIN_TIME_SLICE_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_TIME_SLICE_SCHEDULER_MACROS_SVH

// same-cycle implication, off during reset
`define RRTS_AST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rrts: check failed");

// next-cycle implication, off during reset
`define RRTS_AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rrts: check failed");

`endif

/* rtl/rrts_pkg.sv */
// Package for the round-robin time-slice scheduler: sizes, codes, cell structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rrts_pkg;

  localparam int MAX_PROCESSES = 16;
  localparam int TIME_WIDTH    = 16;
  localparam int IDX_W         = $clog2(MAX_PROCESSES);
  localparam int CNT_W         = $clog2(MAX_PROCESSES + 1);
  localparam int SLICE_W       = 8;
  localparam int STATUS_W      = 2;

  localparam logic [SLICE_W-1:0] SLICE_RESET = SLICE_W'(1);

  // input word kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_LOADED  = 2'd0,
    ST_FULL    = 2'd1,
    ST_SERVED  = 2'd2,
    ST_NOREADY = 2'd3
  } status_t;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic               seed_go;   // place the scan token at the start cell
    logic               shift;     // move the token one cell on
    logic               clr;       // drop the token
    logic               scan;      // scan in progress, a hit is served
    logic [SLICE_W-1:0] slice_len;
  } cell_ctrl_t;

  // per-cell report back to the sequencer
  typedef struct packed {
    logic                  hit;    // token here on a ready entry
    logic                  fin;    // entry finishes with this slice
    logic [TIME_WIDTH-1:0] sum;    // executed time after this slice
  } cell_stat_t;

endpackage

`default_nettype wire

/* rtl/rrts_if.sv */
// Handshake interfaces for the scheduler: input word, result word, config write.
// Depends on rrts_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface rrts_in_if;
  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic [rrts_pkg::TIME_WIDTH-1:0] req_ticks;

  modport source (output valid, kind, req_ticks, input ready);
  modport sink   (input valid, kind, req_ticks, output ready);
endinterface

interface rrts_out_if;
  logic                            valid;
  logic                            ready;
  logic [rrts_pkg::STATUS_W-1:0]   status;
  logic [rrts_pkg::IDX_W-1:0]      index;
  logic [rrts_pkg::TIME_WIDTH-1:0] run_ticks;
  logic                            finished;
  logic                            all_done;

  modport source (output valid, status, index, run_ticks, finished, all_done,
                  input ready);
  modport sink   (input valid, status, index, run_ticks, finished, all_done,
                  output ready);
endinterface

interface rrts_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [rrts_pkg::SLICE_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

/* rtl/rrts_cell.sv */
// One process-entry cell: required time, executed time, finished mark, scan token.
// Depends on rrts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rrts_cell (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire rrts_pkg::cell_ctrl_t            ctrl,
  input  wire logic                            valid,      // entry is loaded
  input  wire logic                            seed,       // this cell starts the scan
  input  wire logic                            load_en,
  input  wire logic [rrts_pkg::TIME_WIDTH-1:0] load_need,
  input  wire logic                            tok_in,     // token from the neighbor
  output logic                                 tok_out,
  output rrts_pkg::cell_stat_t                 stat
);

  logic                            tok_r;
  logic                            fin_r;
  logic [rrts_pkg::TIME_WIDTH-1:0] need_r;
  logic [rrts_pkg::TIME_WIDTH-1:0] done_r;
  logic [rrts_pkg::TIME_WIDTH:0]   raw_sum;
  logic                            serve;

  // saturating add of the slice, finish compare
  always_comb begin
    raw_sum   = {1'b0, done_r} + (rrts_pkg::TIME_WIDTH + 1)'(ctrl.slice_len);
    stat.hit  = tok_r & valid & ~fin_r;
    stat.sum  = raw_sum[rrts_pkg::TIME_WIDTH] ? '1 : raw_sum[rrts_pkg::TIME_WIDTH-1:0];
    stat.fin  = (stat.sum >= need_r);
    serve     = ctrl.scan & stat.hit;
  end

  assign tok_out = tok_r;

  // token and finished mark
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
      fin_r <= 1'b0;
    end else begin
      if (ctrl.clr) begin
        tok_r <= 1'b0;
      end else if (ctrl.seed_go) begin
        tok_r <= seed;
      end else if (ctrl.shift) begin
        tok_r <= tok_in & valid;
      end
      if (load_en) begin
        fin_r <= 1'b0;
      end else if (serve && stat.fin) begin
        fin_r <= 1'b1;
      end
    end
  end

  // entry times
  always_ff @(posedge clk) begin
    if (load_en) begin
      need_r <= load_need;
      done_r <= '0;
    end else if (serve) begin
      done_r <= stat.sum;
    end
  end

endmodule

`default_nettype wire

/* rtl/round_robin_time_slice_scheduler.sv */
// Round-robin time-slice scheduler: one word in, one result word out.
// A load, or a tick on an empty table, gives a registered result straight from idle; other
// ticks move the scan token from the turn pointer until it finds a ready entry or ends.
// Throughput: one word in flight; next word accepted the cycle after the result is taken.
// rst_n (sync, active low) empties the table, clears pointer and counts,
// sets the slice length to 1. Depends on rrts_pkg, rrts_if, rrts_cell, macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "round_robin_time_slice_scheduler_macros.svh"

module round_robin_time_slice_scheduler (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rrts_in_if.sink    in_bus,
  rrts_out_if.source out_bus,
  rrts_cfg_if.sink   cfg_bus
);

  localparam int N = rrts_pkg::MAX_PROCESSES;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t                             state_r;
  logic [rrts_pkg::CNT_W-1:0]         cnt_r;
  logic [rrts_pkg::CNT_W-1:0]         fcnt_r;
  logic [rrts_pkg::CNT_W-1:0]         step_r;
  logic [rrts_pkg::IDX_W-1:0]         ptr_r;
  logic [rrts_pkg::SLICE_W-1:0]       slice_r;
  logic                               out_valid_r;
  rrts_pkg::status_t                  out_status_r;
  logic [rrts_pkg::IDX_W-1:0]         out_index_r;
  logic [rrts_pkg::TIME_WIDTH-1:0]    out_time_r;
  logic                               out_fin_r;
  logic                               out_all_r;

  rrts_pkg::cell_ctrl_t               ctrl;
  rrts_pkg::cell_stat_t               stat [N];
  logic [N-1:0]                       tok_vec;
  logic [N-1:0]                       hit_vec;
  logic [N-1:0]                       valid_vec;
  logic [N-1:0]                       seed_vec;
  logic [N-1:0]                       load_vec;
  logic [N-1:0]                       tok_in_vec;

  logic                               in_fire;
  logic                               is_load;
  logic                               tbl_full;
  logic [rrts_pkg::IDX_W-1:0]         start_idx;
  logic [rrts_pkg::IDX_W-1:0]         last_idx;
  logic                               any_hit;
  logic                               last_step;
  logic [rrts_pkg::IDX_W-1:0]         srv_idx;
  logic [rrts_pkg::TIME_WIDTH-1:0]    srv_sum;
  logic                               srv_fin;
  logic [rrts_pkg::CNT_W-1:0]         fcnt_srv;

  // handshakes
  assign in_bus.ready  = (state_r == S_IDLE) && !out_valid_r;
  assign in_fire       = in_bus.valid && in_bus.ready;
  assign is_load       = (in_bus.kind == rrts_pkg::KIND_LOAD);
  assign cfg_bus.ready = 1'b1;

  assign out_bus.valid     = out_valid_r;
  assign out_bus.status    = out_status_r;
  assign out_bus.index     = out_index_r;
  assign out_bus.run_ticks = out_time_r;
  assign out_bus.finished  = out_fin_r;
  assign out_bus.all_done  = out_all_r;

  // scan start and ring wrap point
  assign tbl_full  = (cnt_r == rrts_pkg::CNT_W'(N));
  assign start_idx = (rrts_pkg::CNT_W'(ptr_r) < cnt_r) ? ptr_r : '0;
  assign last_idx  = rrts_pkg::IDX_W'(cnt_r - 1'b1);
  assign any_hit   = |hit_vec;
  assign last_step = (step_r == cnt_r - 1'b1);
  assign fcnt_srv  = fcnt_r + rrts_pkg::CNT_W'(srv_fin);

  // cell control
  always_comb begin
    ctrl.seed_go   = in_fire && !is_load && (cnt_r != '0);
    ctrl.scan      = (state_r == S_SCAN);
    ctrl.clr       = ctrl.scan && (any_hit || last_step);
    ctrl.shift     = ctrl.scan && !any_hit && !last_step;
    ctrl.slice_len = slice_r;
  end

  // per-cell selects and neighbor links
  always_comb begin
    for (int i = 0; i < N; i++) begin
      valid_vec[i] = (rrts_pkg::CNT_W'(i) < cnt_r);
      seed_vec[i]  = (rrts_pkg::IDX_W'(i) == start_idx);
      load_vec[i]  = in_fire && is_load && !tbl_full &&
                     (rrts_pkg::IDX_W'(i) == cnt_r[rrts_pkg::IDX_W-1:0]);
      hit_vec[i]   = stat[i].hit;
      tok_in_vec[i] = (i == 0) ? tok_vec[last_idx] : tok_vec[(i + N - 1) % N];
    end
  end

  // gather the served cell's report
  always_comb begin
    srv_idx = '0;
    srv_sum = '0;
    srv_fin = 1'b0;
    for (int i = 0; i < N; i++) begin
      if (stat[i].hit) begin
        srv_idx = srv_idx | rrts_pkg::IDX_W'(i);
        srv_sum = srv_sum | stat[i].sum;
        srv_fin = srv_fin | stat[i].fin;
      end
    end
  end

  // cell row
  for (genvar g = 0; g < N; g++) begin : g_cell
    rrts_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .valid     (valid_vec[g]),
      .seed      (seed_vec[g]),
      .load_en   (load_vec[g]),
      .load_need (in_bus.req_ticks),
      .tok_in    (tok_in_vec[g]),
      .tok_out   (tok_vec[g]),
      .stat      (stat[g])
    );
  end

  // sequencer, counters and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      fcnt_r      <= '0;
      step_r      <= '0;
      ptr_r       <= '0;
      slice_r     <= rrts_pkg::SLICE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_bus.valid) begin
        slice_r <= cfg_bus.data;
      end
      if (out_valid_r && out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (is_load) begin
              out_valid_r <= 1'b1;
              out_time_r  <= '0;
              out_fin_r   <= 1'b0;
              if (tbl_full) begin
                out_status_r <= rrts_pkg::ST_FULL;
                out_index_r  <= '0;
                out_all_r    <= (fcnt_r == cnt_r);
              end else begin
                out_status_r <= rrts_pkg::ST_LOADED;
                out_index_r  <= cnt_r[rrts_pkg::IDX_W-1:0];
                out_all_r    <= (fcnt_r == cnt_r + 1'b1);
                cnt_r        <= cnt_r + 1'b1;
              end
            end else if (cnt_r == '0) begin
              out_valid_r  <= 1'b1;
              out_status_r <= rrts_pkg::ST_NOREADY;
              out_index_r  <= '0;
              out_time_r   <= '0;
              out_fin_r    <= 1'b0;
              out_all_r    <= (fcnt_r == cnt_r);
            end else begin
              step_r  <= '0;
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (any_hit) begin
            out_valid_r  <= 1'b1;
            out_status_r <= rrts_pkg::ST_SERVED;
            out_index_r  <= srv_idx;
            out_time_r   <= srv_sum;
            out_fin_r    <= srv_fin;
            out_all_r    <= (fcnt_srv == cnt_r);
            fcnt_r       <= fcnt_srv;
            ptr_r        <= (srv_idx == rrts_pkg::IDX_W'(N - 1)) ? '0 : srv_idx + 1'b1;
            state_r      <= S_IDLE;
          end else if (last_step) begin
            out_valid_r  <= 1'b1;
            out_status_r <= rrts_pkg::ST_NOREADY;
            out_index_r  <= '0;
            out_time_r   <= '0;
            out_fin_r    <= 1'b0;
            out_all_r    <= (fcnt_r == cnt_r);
            state_r      <= S_IDLE;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  `RRTS_AST(a_one_token_hit, 1'b1, $onehot0(hit_vec))
  `RRTS_AST(a_scan_no_pending, state_r == S_SCAN, !out_valid_r)
  `RRTS_AST(a_fin_le_count, 1'b1, fcnt_r <= cnt_r)
  `RRTS_AST_NXT(a_hit_served, ctrl.scan && any_hit, out_valid_r && out_status_r == rrts_pkg::ST_SERVED)

endmodule

`default_nettype wire

/* tb/rrts_schedule_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the round-robin time-slice scheduler. It watches the input,
// result and time-slice channels, predicts every result word and compares it.
// Depends on rrts_pkg and the interfaces in rrts_if.sv.

module rrts_schedule_checker (
  input  wire logic   clk,
  input  wire logic   rst_n,
  rrts_in_if          in_mon,
  rrts_out_if         out_mon,
  rrts_cfg_if         cfg_mon,
  output int unsigned outstanding,
  output int unsigned mismatches,
  output int unsigned served_words,
  output int unsigned finished_words,
  output int unsigned saturated_words,
  output int unsigned full_words,
  output int unsigned idle_words
);
  import rrts_pkg::*;

  localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;
  localparam int unsigned REPORT_LIMIT = 200;

  typedef struct packed {
    status_t               status;
    logic [IDX_W-1:0]      index;
    logic [TIME_WIDTH-1:0] executed;
    logic                  finished;
    logic                  all_done;
  } sched_result_t;

  // shadow copy of the process table
  logic [TIME_WIDTH-1:0]    need_time [MAX_PROCESSES];
  logic [TIME_WIDTH-1:0]    done_time [MAX_PROCESSES];
  logic [MAX_PROCESSES-1:0] retired;
  int unsigned              loaded;
  int unsigned              completed;
  int unsigned              turn;
  logic [SLICE_W-1:0]       slice;

  sched_result_t pending_results[$];

  // apply one input word to the shadow table, return the result it must give
  function automatic sched_result_t schedule_word(input logic kind,
                                                  input logic [TIME_WIDTH-1:0] need);
    sched_result_t       res;
    int unsigned         first;
    int unsigned         slot;
    int unsigned         k;
    logic [TIME_WIDTH:0] sum;
    logic                hit;
    res = '0;
    hit = 1'b0;
    if (kind == KIND_LOAD) begin
      if (loaded >= MAX_PROCESSES) begin
        res.status = ST_FULL;
        full_words++;
      end else begin
        need_time[loaded] = need;
        done_time[loaded] = '0;
        retired[loaded]   = 1'b0;
        res.status = ST_LOADED;
        res.index  = IDX_W'(loaded);
        loaded++;
      end
    end else begin
      res.status = ST_NOREADY;
      // pointer past the loaded entries restarts the scan at entry 0
      first = (turn < loaded) ? turn : 0;
      for (k = 0; k < loaded && !hit; k++) begin
        slot = first + k;
        if (slot >= loaded) slot -= loaded;
        if (!retired[slot]) begin
          hit = 1'b1;
          sum = {1'b0, done_time[slot]} + slice;
          if (sum > TIME_MAX) begin
            sum = TIME_MAX;
            saturated_words++;
          end
          done_time[slot] = sum[TIME_WIDTH-1:0];
          if (done_time[slot] >= need_time[slot]) begin
            retired[slot] = 1'b1;
            completed++;
            res.finished = 1'b1;
            finished_words++;
          end
          turn = (slot + 1) % MAX_PROCESSES;
          res.status   = ST_SERVED;
          res.index    = IDX_W'(slot);
          res.executed = done_time[slot];
          served_words++;
        end
      end
      if (!hit) idle_words++;
    end
    res.all_done = (completed == loaded);
    return res;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want_v, got_v);
    end
  endtask

  // predict on accepted input words, compare on accepted result words
  always @(posedge clk) begin : watch
    sched_result_t want;
    if (!rst_n) begin
      retired   = '0;
      loaded    = 0;
      completed = 0;
      turn      = 0;
      slice     = SLICE_RESET;
      pending_results.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) slice = cfg_mon.data;
      if (in_mon.valid && in_mon.ready)
        pending_results.push_back(schedule_word(in_mon.kind, in_mon.req_ticks));
      if (out_mon.valid && out_mon.ready) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: result word with none pending: expected none, %s %0d index %0d",
                     $time, "actual status", out_mon.status, out_mon.index);
        end else begin
          want = pending_results.pop_front();
          check_field("status", want.status, out_mon.status);
          check_field("index", want.index, out_mon.index);
          check_field("run_ticks", want.executed, out_mon.run_ticks);
          check_field("finished", want.finished, out_mon.finished);
          check_field("all_done", want.all_done, out_mon.all_done);
        end
      end
    end
    outstanding <= pending_results.size();
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Top of the scheduler testbench: clock, reset, stimulus, receiver stalls, verdict.
// Depends on rrts_pkg, rrts_if.sv, the scheduler RTL and rrts_schedule_checker.

module tb_top;
  import rrts_pkg::*;

  localparam int RANDOM_WORDS = 1238;
  localparam int PHASES       = 8;
  localparam int PHASE_WORDS  = RANDOM_WORDS / PHASES;
  localparam int DRAIN_CYCLES = MAX_PROCESSES + 4;
  localparam int CYCLE_LIMIT  = 500000;

  typedef enum logic [1:0] {RDY_ALWAYS, RDY_COIN, RDY_EVERY4, RDY_SPARSE} ready_mode_t;

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  int unsigned cycle_count = 0;
  logic [7:0]  ready_clock = '0;
  ready_mode_t ready_mode  = RDY_ALWAYS;

  int unsigned load_words   = 0;
  int unsigned tick_words   = 0;
  int unsigned slice_writes = 0;

  int unsigned outstanding;
  int unsigned mismatches;
  int unsigned served_words;
  int unsigned finished_words;
  int unsigned saturated_words;
  int unsigned full_words;
  int unsigned idle_words;

  rrts_in_if  in_bus ();
  rrts_out_if out_bus ();
  rrts_cfg_if cfg_bus ();

  round_robin_time_slice_scheduler dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  rrts_schedule_checker sched_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_bus),
    .out_mon         (out_bus),
    .cfg_mon         (cfg_bus),
    .outstanding     (outstanding),
    .mismatches      (mismatches),
    .served_words    (served_words),
    .finished_words  (finished_words),
    .saturated_words (saturated_words),
    .full_words      (full_words),
    .idle_words      (idle_words)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // receiver stalls: a new pattern whenever ready_clock wraps, held off during reset
  always @(posedge clk) begin
    ready_clock <= ready_clock + 1'b1;
    if (ready_clock == '1) ready_mode <= ready_mode_t'($urandom_range(0, 3));
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      case (ready_mode)
        RDY_ALWAYS: out_bus.ready <= 1'b1;
        RDY_COIN:   out_bus.ready <= ($urandom_range(0, 1) == 1);
        RDY_EVERY4: out_bus.ready <= (ready_clock[1:0] == 2'b11);
        default:    out_bus.ready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  // present one word and hold it until taken; valid stays high for the next word
  task automatic send_word(input logic kind, input logic [TIME_WIDTH-1:0] need);
    in_bus.valid     <= 1'b1;
    in_bus.kind      <= kind;
    in_bus.req_ticks <= need;
    do @(posedge clk); while (!in_bus.ready);
    if (kind == KIND_LOAD) load_words++;
    else tick_words++;
  endtask

  // stop sending and wait until every predicted result word has come back
  task automatic drain_results();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // time slice is only changed while the scheduler is idle
  task automatic write_slice(input logic [SLICE_W-1:0] value);
    drain_results();
    repeat (2) @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    slice_writes++;
  endtask

  initial begin : stimulus
    int unsigned           n;
    int unsigned           burst_left;
    int unsigned           gap;
    int unsigned           pick;
    logic [TIME_WIDTH-1:0] need;
    in_bus.valid     <= 1'b0;
    in_bus.kind      <= KIND_LOAD;
    in_bus.req_ticks <= '0;
    cfg_bus.valid    <= 1'b0;
    cfg_bus.data     <= SLICE_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, zero and maximum required time, slice of zero,
    // pointer past the loaded entries, wrap of the scan
    send_word(KIND_TICK, '1);
    send_word(KIND_LOAD, '0);
    send_word(KIND_TICK, '0);
    send_word(KIND_TICK, '1);
    send_word(KIND_LOAD, '1);
    write_slice(8'd0);
    send_word(KIND_TICK, '0);
    send_word(KIND_LOAD, '0);
    send_word(KIND_TICK, '1);
    write_slice(8'd255);
    send_word(KIND_TICK, '0);
    send_word(KIND_LOAD, 16'hAAAA);
    send_word(KIND_TICK, '1);
    send_word(KIND_TICK, '0);

    // random: mostly ticks, sparse loads, a new slice setting every PHASE_WORDS words
    burst_left = $urandom_range(1, 24);
    for (n = 0; n < RANDOM_WORDS; n++) begin
      if (n % PHASE_WORDS == 0) begin
        case (n / PHASE_WORDS)
          0:       write_slice(8'd255);
          1:       write_slice(8'd1);
          2:       write_slice(8'd255);
          3:       write_slice(8'd0);
          4:       write_slice(8'd200);
          5:       write_slice(SLICE_W'($urandom_range(2, 254)));
          6:       write_slice(8'd37);
          default: write_slice(8'd255);
        endcase
      end
      if ($urandom_range(0, 29) == 0) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) need = '1;
        else if (pick == 1) need = TIME_WIDTH'($urandom_range(60000, 65535));
        else if (pick <= 3) need = '0;
        else need = TIME_WIDTH'($urandom_range(1, 3000));
        send_word(KIND_LOAD, need);
      end else begin
        send_word(KIND_TICK, TIME_WIDTH'($urandom));
      end
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          in_bus.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d loads and %0d ticks under %0d time-slice settings.",
             load_words, tick_words, slice_writes);
    $display("Served %0d (%0d finished, %0d saturated), %0d table full, %0d nothing ready.",
             served_words, finished_words, saturated_words, full_words, idle_words);
    if (mismatches == 0 && outstanding == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // watchdog
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, outstanding);
    $display("Verification failed");
    $finish;
  end

endmodule
